// ===== rtl/bba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the buddy block allocator
// Command and status codes, controller states, the control and status
// structures between controller and datapath, and bitmap layout helpers.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_BLOCKS_DEF = 1024;
  localparam int TOTAL_RESET    = 1024;
  localparam int WORD_W         = 32;
  localparam int WORD_BITS      = 5;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NOMEM = 2'd2
  } status_code_t;

  typedef enum logic [3:0] {
    S_RCLR, S_IDLE, S_DISP, S_ICLR, S_DEC, S_SRD, S_SCHK,
    S_SPLIT, S_FRD, S_FCHK, S_DONE
  } state_t;

  typedef struct packed {
    logic         take;
    logic         clr_start;
    logic         clr_step;
    logic         dec_start;
    logic         dec_step;
    logic         srch_start;
    logic         srch_rd;
    logic         srch_next;
    logic         srch_take;
    logic         split_step;
    logic         free_start;
    logic         free_merge;
    logic         free_set;
    logic         res_set;
    logic         res_grant;
    status_code_t res_code;
    logic         out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_code_t cmd;
    logic      size_zero;
    logic      want_over;
    logic      free_skip;
    logic      clr_last;
    logic      dec_last;
    logic      srch_hit;
    logic      srch_end;
    logic      split_done;
    logic      can_merge;
    logic      out_free;
  } dp_stat_t;

  // Highest level whose block still fits in the pool.
  function automatic int max_level(input int mb);
    int l;
    l = 0;
    while ((2 << l) <= mb) l++;
    return l;
  endfunction

  // Bitmap words taken by one level.
  function automatic int level_rows(input int mb, input int l);
    int cnt;
    cnt = ((mb - 1) >> l) + 1;
    return (cnt + WORD_W - 1) / WORD_W;
  endfunction

  // First bitmap word of a level; levels are stored back to back.
  function automatic int row_base(input int mb, input int l);
    int s;
    s = 0;
    for (int k = 0; k < l; k++) s += level_rows(mb, k);
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/buddy_block_allocator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator_top: buddy allocator over a pool of blocks
// Init, allocate and free commands with one result per transaction.
// ----------------------------------------------------------------------------
// The free state lives in per-level bitmaps packed into 32-bit RAM words
// (68 words for 1024 blocks), reached through one read and one write port.
// After reset a clearing pass writes every word, one per cycle, before the
// first transaction is taken; configuration writes are taken at any time.
// Each transaction is accepted and dispatched. Init then clears every word
// and sets the free blocks of the pool level by level; allocate scans bitmap
// words from the wanted level upward and splits the block found down to it;
// free merges the block with free buddies level by level, then marks it
// free. Search and merge read a word from the registered RAM in one state
// and check it in a second. The pool size written through the configuration
// channel takes effect at the next init. A finished result waits in the
// output register until it is taken.
module buddy_block_allocator_top
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [10:0] request_size,
  input  wire logic [9:0]  block_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [9:0]       granted_index
);

  dp_cmd_t  dc;
  dp_stat_t st;

  // Sequencer.
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .dc       (dc)
  );

  // Bitmaps, walk registers and result.
  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .request_size  (request_size),
    .block_index   (block_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .granted_index (granted_index),
    .dc            (dc),
    .st            (st)
  );

endmodule
`default_nettype wire

// ===== rtl/bba_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/bba_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl: sequencer of the buddy block allocator
// Steps through clearing, decomposition, search, split and merge by issuing
// commands to the datapath and reading its status flags.
// ----------------------------------------------------------------------------
module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t st,
  output dp_cmd_t       dc
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RCLR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    dc         = '0;
    dc.res_code = ST_OK;
    in_ready   = 1'b0;
    unique case (state)
      S_RCLR: begin
        dc.clr_step = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dc.take    = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.cmd)
          CMD_INIT: begin
            dc.clr_start = 1'b1;
            state_next   = S_ICLR;
          end
          CMD_ALLOC: begin
            if (st.size_zero) begin
              dc.res_set  = 1'b1;
              dc.res_code = ST_ZERO;
              state_next  = S_DONE;
            end else if (st.want_over) begin
              dc.res_set  = 1'b1;
              dc.res_code = ST_NOMEM;
              state_next  = S_DONE;
            end else begin
              dc.srch_start = 1'b1;
              state_next    = S_SRD;
            end
          end
          CMD_FREE: begin
            if (st.size_zero) begin
              dc.res_set  = 1'b1;
              dc.res_code = ST_ZERO;
              state_next  = S_DONE;
            end else if (st.free_skip) begin
              dc.res_set = 1'b1;
              state_next = S_DONE;
            end else begin
              dc.free_start = 1'b1;
              state_next    = S_FRD;
            end
          end
          default: begin
            dc.res_set = 1'b1;
            state_next = S_DONE;
          end
        endcase
      end
      S_ICLR: begin
        dc.clr_step = 1'b1;
        if (st.clr_last) begin
          dc.dec_start = 1'b1;
          state_next   = S_DEC;
        end
      end
      S_DEC: begin
        dc.dec_step = 1'b1;
        if (st.dec_last) begin
          dc.res_set = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SRD: begin
        dc.srch_rd = 1'b1;
        state_next = S_SCHK;
      end
      S_SCHK: begin
        if (st.srch_hit) begin
          dc.srch_take = 1'b1;
          state_next   = S_SPLIT;
        end else if (st.srch_end) begin
          dc.res_set  = 1'b1;
          dc.res_code = ST_NOMEM;
          state_next  = S_DONE;
        end else begin
          dc.srch_next = 1'b1;
          state_next   = S_SRD;
        end
      end
      S_SPLIT: begin
        if (st.split_done) begin
          dc.res_set   = 1'b1;
          dc.res_grant = 1'b1;
          state_next   = S_DONE;
        end else begin
          dc.split_step = 1'b1;
        end
      end
      S_FRD: begin
        state_next = S_FCHK;
      end
      S_FCHK: begin
        if (st.can_merge) begin
          dc.free_merge = 1'b1;
          state_next    = S_FRD;
        end else begin
          dc.free_set = 1'b1;
          dc.res_set  = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          dc.out_load = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bba_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_dp: datapath of the buddy block allocator
// Holds the per-level free bitmaps in RAM words, the walk registers, the
// pool size register and the result register.
// ----------------------------------------------------------------------------
module bba_dp
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [10:0] request_size,
  input  wire logic [9:0]  block_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [9:0]       granted_index,
  input  wire dp_cmd_t     dc,
  output dp_stat_t         st
);

  localparam int MAX_LEVEL = max_level(MAX_BLOCKS);
  localparam int LW        = $clog2(MAX_LEVEL + 2);
  localparam int IW        = MAX_LEVEL + 1;
  localparam int NW        = (IW > 11) ? IW : 11;
  localparam int ROWS      = row_base(MAX_BLOCKS, MAX_LEVEL + 1);
  localparam int AW        = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [10:0]       total_blocks;
  cmd_code_t         cmd_q;
  logic [10:0]       size_q;
  logic [9:0]        block_q;
  logic [LW-1:0]     top_level;
  logic [LW-1:0]     lvl;
  logic [IW-1:0]     ent;
  logic [IW-1:0]     pos;
  logic [AW-1:0]     rowp;
  status_code_t      res_code;
  logic [IW-1:0]     res_grant;
  logic [1:0]        status_q;
  logic [IW-1:0]     grant_q;
  logic              out_valid_q;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] rdata;

  logic [AW-1:0]        row_base_c [MAX_LEVEL+1];
  logic [AW-1:0]        row_last_c [MAX_LEVEL+1];
  logic [LW-1:0]        req_lvl;
  logic [NW-1:0]        n_clamp;
  logic [LW-1:0]        n_top;
  logic                 hit;
  logic [WORD_BITS-1:0] hit_bit;
  logic [IW-1:0]        ent_hit;
  logic [LW-1:0]        lvl_dn;
  logic [IW-1:0]        ent_dn;
  logic [IW-1:0]        pos_sh;
  logic [IW-1:0]        ent_x;
  logic                 n_bit;

  // Layout of the bitmap words, fixed at elaboration.
  for (genvar g = 0; g <= MAX_LEVEL; g++) begin : g_layout
    assign row_base_c[g] = AW'(row_base(MAX_BLOCKS, g));
    assign row_last_c[g] = AW'(row_base(MAX_BLOCKS, g + 1) - 1);
  end

  function automatic logic [AW-1:0] row_of(input logic [AW-1:0] base,
                                           input logic [IW-1:0] e);
    return base + AW'(e >> WORD_BITS);
  endfunction

  function automatic logic [WORD_W-1:0] one_hot(input logic [IW-1:0] e);
    logic [WORD_BITS-1:0] b;
    b = WORD_BITS'(e);
    return WORD_W'(1) << b;
  endfunction

  // Level of the request: size rounded up to a power of two, capped.
  always_comb begin
    logic [10:0] sm1;
    int          p;
    sm1 = size_q - 11'd1;
    p   = 0;
    for (int i = 0; i < 11; i++) begin
      if (sm1[i]) p = i + 1;
    end
    req_lvl = (p > MAX_LEVEL) ? LW'(MAX_LEVEL + 1) : LW'(p);
  end

  // Pool size limited to the store, and its highest set bit.
  always_comb begin
    n_clamp = (NW'(total_blocks) > NW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : NW'(total_blocks);
    n_top   = '0;
    for (int i = 0; i <= MAX_LEVEL; i++) begin
      if (n_clamp[i]) n_top = LW'(i);
    end
  end

  // Lowest free entry in the word just read.
  always_comb begin
    hit     = |rdata;
    hit_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (rdata[i]) hit_bit = WORD_BITS'(i);
    end
    ent_hit = IW'({rowp - row_base_c[lvl], hit_bit});
  end

  assign lvl_dn = lvl - LW'(1);
  assign ent_dn = IW'({ent, 1'b0});
  assign pos_sh = pos >> lvl;
  assign ent_x  = ent ^ IW'(1);
  assign n_bit  = n_clamp[0 +: NW] >> lvl != '0 ? ((n_clamp >> lvl) & NW'(1)) != '0 : 1'b0;

  // Bitmap write port.
  always_comb begin
    we    = 1'b0;
    waddr = rowp;
    wdata = '0;
    if (dc.clr_step) begin
      we = 1'b1;
    end else if (dc.dec_step) begin
      we    = n_bit;
      waddr = row_of(row_base_c[lvl], pos_sh);
      wdata = one_hot(pos_sh);
    end else if (dc.srch_take) begin
      we    = 1'b1;
      wdata = rdata & ~(WORD_W'(1) << hit_bit);
    end else if (dc.split_step) begin
      we    = 1'b1;
      waddr = row_of(row_base_c[lvl_dn], ent_dn);
      wdata = one_hot(ent_dn);
    end else if (dc.free_merge) begin
      we    = 1'b1;
      waddr = row_of(row_base_c[lvl], ent);
      wdata = rdata & ~one_hot(ent_x);
    end else if (dc.free_set) begin
      we    = 1'b1;
      waddr = row_of(row_base_c[lvl], ent);
      wdata = rdata | one_hot(ent);
    end
  end

  assign raddr = dc.srch_rd ? rowp : row_of(row_base_c[lvl], ent);

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Control registers: pool size, top level, word pointer, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= 11'(TOTAL_RESET);
      top_level    <= '0;
      rowp         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid) total_blocks <= cfg_data;
      if (dc.dec_start) top_level <= n_top;
      if (dc.clr_start) begin
        rowp <= '0;
      end else if (dc.clr_step || dc.srch_next) begin
        rowp <= rowp + AW'(1);
      end else if (dc.srch_start) begin
        rowp <= row_base_c[req_lvl];
      end
      if (dc.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Transaction capture, walk registers and result.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q   <= cmd_code_t'(cmd);
      size_q  <= request_size;
      block_q <= block_index;
    end
    if (dc.dec_start) begin
      lvl <= LW'(MAX_LEVEL);
      pos <= '0;
    end else if (dc.dec_step) begin
      lvl <= lvl_dn;
      if (n_bit) pos <= pos + (IW'(1) << lvl);
    end else if (dc.srch_start) begin
      lvl <= req_lvl;
    end else if (dc.srch_next) begin
      if (rowp == row_last_c[lvl]) lvl <= lvl + LW'(1);
    end else if (dc.srch_take) begin
      ent <= ent_hit;
    end else if (dc.split_step) begin
      lvl <= lvl_dn;
      ent <= ent_dn | IW'(1);
    end else if (dc.free_start) begin
      lvl <= req_lvl;
      ent <= IW'(block_q) >> req_lvl;
    end else if (dc.free_merge) begin
      lvl <= lvl + LW'(1);
      ent <= ent >> 1;
    end
    if (dc.res_set) begin
      res_code  <= dc.res_code;
      res_grant <= dc.res_grant ? (ent << lvl) : '0;
    end
    if (dc.out_load) begin
      status_q <= res_code;
      grant_q  <= res_grant;
    end
  end

  // Status flags for the controller.
  always_comb begin
    st            = '0;
    st.cmd        = cmd_q;
    st.size_zero  = (size_q == 11'd0);
    st.want_over  = (req_lvl > top_level);
    st.free_skip  = (req_lvl > top_level) || (32'(block_q) >= 32'(MAX_BLOCKS));
    st.clr_last   = (rowp == AW'(ROWS - 1));
    st.dec_last   = (lvl == '0);
    st.srch_hit   = hit;
    st.srch_end   = (lvl == top_level) && (rowp == row_last_c[lvl]);
    st.split_done = (lvl == req_lvl);
    st.can_merge  = (lvl < top_level) && ((rdata & one_hot(ent_x)) != '0);
    st.out_free   = !out_valid_q || out_ready;
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_q;
  assign status        = status_q;
  assign granted_index = 10'(grant_q);

  // Bitmap writes stay inside the store.
  a_waddr: assert property (@(posedge clk) disable iff (rst)
    we |-> (32'(waddr) < 32'(ROWS)))
    else $error("bitmap write beyond the store");

  // A block is only taken out of a word that shows a free entry.
  a_take: assert property (@(posedge clk) disable iff (rst)
    dc.srch_take |-> (rdata != '0))
    else $error("search took a block from an empty word");

  // The top level never exceeds the largest block of the store.
  a_top: assert property (@(posedge clk) disable iff (rst)
    32'(top_level) <= 32'(MAX_LEVEL))
    else $error("top level out of range");

endmodule
`default_nettype wire
